>>> hdl/tvns_pkg.sv
// shared constants and types for the trauma value-noise view shake
`default_nettype none

package tvns_pkg;

  typedef logic [32:0] mul_op_t;
  typedef logic [1:0]  opcode_t;

  localparam opcode_t OP_TICK  = 2'd0;
  localparam opcode_t OP_ADD   = 2'd1;
  localparam opcode_t OP_CLEAR = 2'd2;

  localparam logic [2:0] REG_CONT_MODE  = 3'd0;
  localparam logic [2:0] REG_CONT_LEVEL = 3'd1;
  localparam logic [2:0] REG_DECAY_RATE = 3'd2;
  localparam logic [2:0] REG_NOISE_SPD  = 3'd3;
  localparam logic [2:0] REG_MAX_OFFSET = 3'd4;

  localparam logic [16:0] TRAUMA_ONE = 17'h10000;

  localparam logic [31:0] HASH_MUL_SAMPLE = 32'd374761393;
  localparam logic [31:0] HASH_MUL_SEED   = 32'd668265263;
  localparam logic [31:0] HASH_MUL_MIX    = 32'd1274126177;
  localparam logic [31:0] SEED_X_MIX      = HASH_MUL_SEED;
  localparam logic [31:0] SEED_Y_MIX      = 32'(HASH_MUL_SEED * 2);

endpackage

`default_nettype wire

>>> hdl/trauma_value_noise_shake.sv
// trauma value-noise view shake: top level with sequencer and shared multiplier
//
// Each input word carries an opcode in tuser: tick, add trauma or clear. One result
// word comes back per input word. Add, clear and the unused opcode go from acceptance
// straight to the result. A tick that ends with trauma at zero stops after the decay
// step; otherwise the tick runs on the single shared 33 x 33 bit multiplier, which
// does fourteen products per full tick (phase step, decay, two for smoothstep, hash
// seeding, trauma scaling, four hash mixes, two noise blends, two offset scalings).
// The input side is not ready while a word is being worked on. The result waits in
// an output register, so the input side is released as soon as it is loaded.
`default_nettype none

module trauma_value_noise_shake
  import tvns_pkg::*;
#(
  parameter int FRAC_BITS      = 16,
  parameter int PHASE_INT_BITS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,     // delta_time[15:0], trauma_amount[31:16]
  input  wire logic [1:0]  in_tuser,     // opcode[1:0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata,    // offset_x[8:0], offset_y[17:9], trauma_level[34:18]
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [4:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  localparam int PW     = PHASE_INT_BITS + FRAC_BITS;
  localparam int INC_SH = 24 - FRAC_BITS;

  localparam logic [4:0] ST_IDLE = 5'd0;
  localparam logic [4:0] ST_INC  = 5'd1;
  localparam logic [4:0] ST_DEC  = 5'd2;
  localparam logic [4:0] ST_TRA  = 5'd3;
  localparam logic [4:0] ST_SQ   = 5'd4;
  localparam logic [4:0] ST_SM   = 5'd5;
  localparam logic [4:0] ST_E    = 5'd6;
  localparam logic [4:0] ST_MT   = 5'd7;
  localparam logic [4:0] ST_MTL  = 5'd8;
  localparam logic [4:0] ST_HPRE = 5'd9;
  localparam logic [4:0] ST_HMUL = 5'd10;
  localparam logic [4:0] ST_HFIN = 5'd11;
  localparam logic [4:0] ST_NMUL = 5'd12;
  localparam logic [4:0] ST_NADD = 5'd13;
  localparam logic [4:0] ST_OMUL = 5'd14;
  localparam logic [4:0] ST_OFIN = 5'd15;
  localparam logic [4:0] ST_OUT  = 5'd16;

  // control state
  logic [4:0]        state_r, state_nxt;
  logic              cont_mode_r, cont_mode_nxt;
  logic [16:0]       cont_level_r, cont_level_nxt;
  logic [15:0]       decay_rate_r, decay_rate_nxt;
  logic [15:0]       noise_speed_r, noise_speed_nxt;
  logic [7:0]        max_offset_r, max_offset_nxt;
  logic [16:0]       trauma_r, trauma_nxt;
  logic [PW-1:0]     phase_r, phase_nxt;
  logic signed [8:0] offx_r, offx_nxt;
  logic signed [8:0] offy_r, offy_nxt;
  logic              out_tvalid_r, out_tvalid_nxt;
  logic              seed_r, seed_nxt;
  logic              pos_r, pos_nxt;

  // datapath
  logic [65:0]       prod_r;
  logic [15:0]       dt_r, dt_nxt;
  logic [31:0]       v_r, v_nxt;
  logic [31:0]       hfrom_r, hfrom_nxt;
  logic [31:0]       hto_r, hto_nxt;
  logic [16:0]       e16_r, e16_nxt;
  logic [31:0]       samp_c1_r, samp_c1_nxt;
  logic [24:0]       mt_r, mt_nxt;
  logic              dneg_r, dneg_nxt;
  logic              nneg_r, nneg_nxt;
  logic [32:0]       nmag_r, nmag_nxt;
  logic [39:0]       out_tdata_r, out_tdata_nxt;

  mul_op_t           mul_a, mul_b;
  logic [65:0]       mul_p;

  logic              in_acc, cfg_wr;
  logic [2:0]        cfg_idx;
  logic [16:0]       level_sat;
  logic [15:0]       frac16;
  logic [31:0]       sample;

  // combinational temporaries
  logic [31:0]        inc_w;
  logic [24:0]        dec_w;
  logic [17:0]        add_w;
  logic [48:0]        e_w;
  logic [31:0]        hv_w, hw_w;
  logic signed [32:0] hd_w;
  logic [31:0]        hmag_w;
  logic signed [33:0] from_q;
  logic signed [51:0] base_w, prodv_w, full_w;
  logic [51:0]        fmag_w;
  logic [57:0]        osum_w;
  logic [8:0]         r9_w;

  assign in_acc     = in_tvalid & in_tready;
  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg_idx    = cfg_paddr[4:2];
  assign level_sat  = (cont_level_r > TRAUMA_ONE) ? TRAUMA_ONE : cont_level_r;
  assign sample     = 32'(phase_r[PW-1:FRAC_BITS]);

  generate
    if (FRAC_BITS >= 16) begin : g_frac_hi
      assign frac16 = phase_r[FRAC_BITS-1 -: 16];
    end else begin : g_frac_lo
      assign frac16 = {phase_r[FRAC_BITS-1:0], {(16-FRAC_BITS){1'b0}}};
    end
  endgenerate

  assign mul_p = mul_a * mul_b;

  always_comb begin
    unique case (cfg_idx)
      REG_CONT_MODE:  cfg_prdata = {31'd0, cont_mode_r};
      REG_CONT_LEVEL: cfg_prdata = {15'd0, cont_level_r};
      REG_DECAY_RATE: cfg_prdata = {16'd0, decay_rate_r};
      REG_NOISE_SPD:  cfg_prdata = {16'd0, noise_speed_r};
      REG_MAX_OFFSET: cfg_prdata = {24'd0, max_offset_r};
      default:        cfg_prdata = 32'd0;
    endcase
  end

  always_comb begin
    state_nxt       = state_r;
    cont_mode_nxt   = cont_mode_r;
    cont_level_nxt  = cont_level_r;
    decay_rate_nxt  = decay_rate_r;
    noise_speed_nxt = noise_speed_r;
    max_offset_nxt  = max_offset_r;
    trauma_nxt      = trauma_r;
    phase_nxt       = phase_r;
    offx_nxt        = offx_r;
    offy_nxt        = offy_r;
    out_tvalid_nxt  = out_tvalid_r & ~out_tready;
    seed_nxt        = seed_r;
    pos_nxt         = pos_r;
    dt_nxt          = dt_r;
    v_nxt           = v_r;
    hfrom_nxt       = hfrom_r;
    hto_nxt         = hto_r;
    e16_nxt         = e16_r;
    samp_c1_nxt     = samp_c1_r;
    mt_nxt          = mt_r;
    dneg_nxt        = dneg_r;
    nneg_nxt        = nneg_r;
    nmag_nxt        = nmag_r;
    out_tdata_nxt   = out_tdata_r;
    mul_a           = '0;
    mul_b           = '0;

    inc_w   = prod_r[31:0] >> INC_SH;
    dec_w   = 25'((33'(prod_r[31:0]) + 33'd128) >> 8);
    add_w   = {1'b0, trauma_r} + {2'b00, in_tdata[31:16]};
    e_w     = 49'(prod_r[47:0]) + 49'h0_8000_0000;
    hv_w    = samp_c1_r + (pos_r ? HASH_MUL_SAMPLE : 32'd0)
              + (seed_r ? SEED_Y_MIX : SEED_X_MIX);
    hw_w    = prod_r[31:0] ^ (prod_r[31:0] >> 16);
    hd_w    = $signed({1'b0, hto_r}) - $signed({1'b0, hfrom_r});
    hmag_w  = hd_w[32] ? 32'(-hd_w) : hd_w[31:0];
    from_q  = $signed({1'b0, hfrom_r, 1'b0}) - 34'sh0_FFFF_FFFF;
    base_w  = 52'(from_q) <<< 16;
    prodv_w = $signed({2'b00, prod_r[49:0]});
    full_w  = dneg_r ? (base_w - prodv_w) : (base_w + prodv_w);
    fmag_w  = full_w[51] ? 52'(-full_w) : 52'(full_w);
    osum_w  = prod_r[57:0] + (58'd1 << 47);
    r9_w    = osum_w[56:48];

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          dt_nxt = in_tdata[15:0];
          unique case (in_tuser)
            OP_TICK: state_nxt = ST_INC;
            OP_ADD: begin
              if (in_tdata[31:16] != 16'd0) begin
                trauma_nxt = (add_w > {1'b0, TRAUMA_ONE}) ? TRAUMA_ONE : add_w[16:0];
              end
              state_nxt = ST_OUT;
            end
            OP_CLEAR: begin
              trauma_nxt = '0;
              offx_nxt   = '0;
              offy_nxt   = '0;
              state_nxt  = ST_OUT;
            end
            default: state_nxt = ST_OUT;
          endcase
        end
      end
      ST_INC: begin
        mul_a     = 33'(dt_r);
        mul_b     = 33'(noise_speed_r);
        state_nxt = ST_DEC;
      end
      ST_DEC: begin
        phase_nxt = phase_r + PW'(inc_w);
        mul_a     = 33'(decay_rate_r);
        mul_b     = 33'(dt_r);
        state_nxt = ST_TRA;
      end
      ST_TRA: begin
        if (cont_mode_r) begin
          trauma_nxt = level_sat;
        end else if (trauma_r != 17'd0) begin
          trauma_nxt = (dec_w >= {8'd0, trauma_r}) ? 17'd0 : (trauma_r - dec_w[16:0]);
        end
        if (trauma_nxt == 17'd0) begin
          offx_nxt  = '0;
          offy_nxt  = '0;
          state_nxt = ST_OUT;
        end else begin
          state_nxt = ST_SQ;
        end
      end
      ST_SQ: begin
        mul_a     = 33'(frac16);
        mul_b     = 33'(frac16);
        state_nxt = ST_SM;
      end
      ST_SM: begin
        mul_a     = 33'(prod_r[31:0]);
        mul_b     = 33'(18'd196608 - {1'b0, frac16, 1'b0});
        state_nxt = ST_E;
      end
      ST_E: begin
        e16_nxt   = e_w[48:32];
        mul_a     = 33'(sample);
        mul_b     = 33'(HASH_MUL_SAMPLE);
        state_nxt = ST_MT;
      end
      ST_MT: begin
        samp_c1_nxt = prod_r[31:0];
        mul_a       = 33'(max_offset_r);
        mul_b       = 33'(trauma_r);
        state_nxt   = ST_MTL;
      end
      ST_MTL: begin
        mt_nxt    = prod_r[24:0];
        seed_nxt  = 1'b0;
        pos_nxt   = 1'b0;
        state_nxt = ST_HPRE;
      end
      ST_HPRE: begin
        v_nxt     = hv_w ^ (hv_w >> 13);
        state_nxt = ST_HMUL;
      end
      ST_HMUL: begin
        mul_a     = 33'(v_r);
        mul_b     = 33'(HASH_MUL_MIX);
        state_nxt = ST_HFIN;
      end
      ST_HFIN: begin
        if (!pos_r) begin
          hfrom_nxt = hw_w;
          pos_nxt   = 1'b1;
          state_nxt = ST_HPRE;
        end else begin
          hto_nxt   = hw_w;
          state_nxt = ST_NMUL;
        end
      end
      ST_NMUL: begin
        dneg_nxt  = hd_w[32];
        mul_a     = {hmag_w, 1'b0};
        mul_b     = 33'(e16_r);
        state_nxt = ST_NADD;
      end
      ST_NADD: begin
        nneg_nxt  = full_w[51];
        nmag_nxt  = 33'((fmag_w + 52'd32768) >> 16);
        state_nxt = ST_OMUL;
      end
      ST_OMUL: begin
        mul_a     = nmag_r;
        mul_b     = 33'(mt_r);
        state_nxt = ST_OFIN;
      end
      ST_OFIN: begin
        if (!seed_r) begin
          offx_nxt  = nneg_r ? $signed(9'd0 - r9_w) : $signed(r9_w);
          seed_nxt  = 1'b1;
          pos_nxt   = 1'b0;
          state_nxt = ST_HPRE;
        end else begin
          offy_nxt  = nneg_r ? $signed(9'd0 - r9_w) : $signed(r9_w);
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = {5'd0, trauma_r, offy_r, offx_r};
          state_nxt      = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    if (cfg_wr) begin
      unique case (cfg_idx)
        REG_CONT_MODE: begin
          cont_mode_nxt = cfg_pwdata[0];
          if (cfg_pwdata[0]) begin
            trauma_nxt = level_sat;
          end
        end
        REG_CONT_LEVEL: cont_level_nxt  = cfg_pwdata[16:0];
        REG_DECAY_RATE: decay_rate_nxt  = cfg_pwdata[15:0];
        REG_NOISE_SPD:  noise_speed_nxt = cfg_pwdata[15:0];
        REG_MAX_OFFSET: max_offset_nxt  = cfg_pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      cont_mode_r   <= 1'b0;
      cont_level_r  <= 17'd32768;
      decay_rate_r  <= 16'd256;
      noise_speed_r <= 16'd2560;
      max_offset_r  <= 8'd16;
      trauma_r      <= '0;
      phase_r       <= '0;
      offx_r        <= '0;
      offy_r        <= '0;
      out_tvalid_r  <= 1'b0;
      seed_r        <= 1'b0;
      pos_r         <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      cont_mode_r   <= cont_mode_nxt;
      cont_level_r  <= cont_level_nxt;
      decay_rate_r  <= decay_rate_nxt;
      noise_speed_r <= noise_speed_nxt;
      max_offset_r  <= max_offset_nxt;
      trauma_r      <= trauma_nxt;
      phase_r       <= phase_nxt;
      offx_r        <= offx_nxt;
      offy_r        <= offy_nxt;
      out_tvalid_r  <= out_tvalid_nxt;
      seed_r        <= seed_nxt;
      pos_r         <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prod_r      <= mul_p;
    dt_r        <= dt_nxt;
    v_r         <= v_nxt;
    hfrom_r     <= hfrom_nxt;
    hto_r       <= hto_nxt;
    e16_r       <= e16_nxt;
    samp_c1_r   <= samp_c1_nxt;
    mt_r        <= mt_nxt;
    dneg_r      <= dneg_nxt;
    nneg_r      <= nneg_nxt;
    nmag_r      <= nmag_nxt;
    out_tdata_r <= out_tdata_nxt;
  end

  a_trauma_range: assert property (@(posedge clk) disable iff (!rst_n)
    trauma_r <= TRAUMA_ONE)
    else $error("trauma above one");

  a_tick_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (in_tuser == OP_TICK) |=> state_r == ST_INC)
    else $error("tick did not start the sequence");

  a_other_direct: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (in_tuser != OP_TICK) |=> state_r == ST_OUT)
    else $error("non-tick word did not go straight to the result");

  a_second_offset_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_OFIN) && seed_r |=> state_r == ST_OUT)
    else $error("sequence did not end after the vertical offset");

  a_offset_range: assert property (@(posedge clk) disable iff (!rst_n)
    (offx_r != 9'sh100) && (offy_r != 9'sh100))
    else $error("offset outside range");

endmodule

`default_nettype wire
